### rtl/blps_pkg.sv
// shared types and constants of the line pixel stepper
`default_nettype none

package blps_pkg;

  // input item kinds carried in tuser
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 32;
  localparam int LEN_W   = 17;
  localparam int ERR_W   = 18;
  localparam int ADDR_W  = 23;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 88;

  // one accepted input transaction
  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        line_color;
  } line_item_t;

  // one stepped pixel before clipping
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic                      last;
  } pixel_t;

endpackage

`default_nettype wire

### rtl/blps_step.sv
// line setup and per-pixel stepping with the error term
`default_nettype none

module blps_step
  import blps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire line_item_t item,
  output logic            item_ready,
  output logic            pix_valid,
  output pixel_t          pix,
  input  wire logic       pix_ready
);

  logic signed [COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic signed [COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic [LEN_W-1:0]          major_len_r, major_len_nxt;
  logic [LEN_W-1:0]          minor_len_r, minor_len_nxt;
  logic [ERR_W-1:0]          error_acc_r, error_acc_nxt;
  logic [LEN_W-1:0]          steps_left_r, steps_left_nxt;
  logic                      x_dir_neg_r, x_dir_neg_nxt;
  logic                      y_dir_neg_r, y_dir_neg_nxt;
  logic                      x_is_major_r, x_is_major_nxt;
  logic [COLOR_W-1:0]        held_color_r, held_color_nxt;
  logic                      line_active_r, line_active_nxt;
  logic                      first_pending_r, first_pending_nxt;
  logic                      pix_valid_r, pix_valid_nxt;
  pixel_t                    pix_r, pix_nxt;

  logic                      fire;
  logic signed [LEN_W-1:0]   dx, dy;
  logic [LEN_W-1:0]          ax, ay;
  logic                      x_major;
  logic [ERR_W-1:0]          err_sum;
  logic                      minor_step;
  logic signed [COORD_W-1:0] x_inc, y_inc;

  assign item_ready = !pix_valid_r || pix_ready;
  assign fire       = item_valid && item_ready;
  assign pix_valid  = pix_valid_r;
  assign pix        = pix_r;

  // line setup terms
  always_comb begin
    dx = LEN_W'(item.end_x) - LEN_W'(item.start_x);
    dy = LEN_W'(item.end_y) - LEN_W'(item.start_y);
    ax = dx[LEN_W-1] ? LEN_W'(-dx) : LEN_W'(dx);
    ay = dy[LEN_W-1] ? LEN_W'(-dy) : LEN_W'(dy);
    x_major = ax > ay;
  end

  // error term and unit moves for the next pixel
  always_comb begin
    err_sum    = error_acc_r + ERR_W'(minor_len_r);
    minor_step = err_sum >= ERR_W'(major_len_r);
    x_inc      = x_dir_neg_r ? -16'sd1 : 16'sd1;
    y_inc      = y_dir_neg_r ? -16'sd1 : 16'sd1;
  end

  // next state
  always_comb begin
    cur_x_nxt         = cur_x_r;
    cur_y_nxt         = cur_y_r;
    major_len_nxt     = major_len_r;
    minor_len_nxt     = minor_len_r;
    error_acc_nxt     = error_acc_r;
    steps_left_nxt    = steps_left_r;
    x_dir_neg_nxt     = x_dir_neg_r;
    y_dir_neg_nxt     = y_dir_neg_r;
    x_is_major_nxt    = x_is_major_r;
    held_color_nxt    = held_color_r;
    line_active_nxt   = line_active_r;
    first_pending_nxt = first_pending_r;
    pix_valid_nxt     = pix_valid_r && !pix_ready;
    pix_nxt           = pix_r;

    if (fire) begin
      pix_valid_nxt = 1'b0;
      if (item.op == OP_LOAD) begin
        cur_x_nxt         = item.start_x;
        cur_y_nxt         = item.start_y;
        x_dir_neg_nxt     = !(dx > 0);
        y_dir_neg_nxt     = !(dy > 0);
        x_is_major_nxt    = x_major;
        major_len_nxt     = x_major ? ax : ay;
        minor_len_nxt     = x_major ? ay : ax;
        error_acc_nxt     = ERR_W'(major_len_nxt >> 1);
        steps_left_nxt    = major_len_nxt;
        held_color_nxt    = item.line_color;
        line_active_nxt   = 1'b1;
        first_pending_nxt = 1'b1;
      end else if (line_active_r) begin
        if (first_pending_r) begin
          first_pending_nxt = 1'b0;
        end else begin
          error_acc_nxt = minor_step ? err_sum - ERR_W'(major_len_r) : err_sum;
          if (x_is_major_r) begin
            cur_x_nxt = cur_x_r + x_inc;
            if (minor_step) cur_y_nxt = cur_y_r + y_inc;
          end else begin
            cur_y_nxt = cur_y_r + y_inc;
            if (minor_step) cur_x_nxt = cur_x_r + x_inc;
          end
          if (steps_left_r != '0) steps_left_nxt = steps_left_r - 1'b1;
        end
        pix_valid_nxt = 1'b1;
        pix_nxt.x     = cur_x_nxt;
        pix_nxt.y     = cur_y_nxt;
        pix_nxt.color = held_color_r;
        pix_nxt.last  = steps_left_nxt == '0;
        if (steps_left_nxt == '0) line_active_nxt = 1'b0;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r         <= '0;
      cur_y_r         <= '0;
      major_len_r     <= '0;
      minor_len_r     <= '0;
      error_acc_r     <= '0;
      steps_left_r    <= '0;
      x_dir_neg_r     <= 1'b0;
      y_dir_neg_r     <= 1'b0;
      x_is_major_r    <= 1'b0;
      held_color_r    <= '0;
      line_active_r   <= 1'b0;
      first_pending_r <= 1'b0;
      pix_valid_r     <= 1'b0;
    end else begin
      cur_x_r         <= cur_x_nxt;
      cur_y_r         <= cur_y_nxt;
      major_len_r     <= major_len_nxt;
      minor_len_r     <= minor_len_nxt;
      error_acc_r     <= error_acc_nxt;
      steps_left_r    <= steps_left_nxt;
      x_dir_neg_r     <= x_dir_neg_nxt;
      y_dir_neg_r     <= y_dir_neg_nxt;
      x_is_major_r    <= x_is_major_nxt;
      held_color_r    <= held_color_nxt;
      line_active_r   <= line_active_nxt;
      first_pending_r <= first_pending_nxt;
      pix_valid_r     <= pix_valid_nxt;
    end
    pix_r <= pix_nxt;
  end

endmodule

`default_nettype wire

### rtl/blps_addr.sv
// canvas clip and framebuffer address, registered onto the output stream
`default_nettype none

module blps_addr
  import blps_pkg::*;
#(
  parameter int CANVAS_SIDE = 2560
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    pix_valid,
  input  wire pixel_t                  pix,
  output logic                         pix_ready,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [OUT_DATA_W-1:0]        out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast
);

  localparam int IDX_W  = 13;
  localparam int FULL_W = 2 * IDX_W - 1;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  in_canvas_r, in_canvas_nxt;
  logic                  last_r, last_nxt;
  logic                  fire;
  logic                  in_canvas;
  logic [FULL_W-1:0]     addr_full;
  logic [ADDR_W-1:0]     addr;

  assign pix_ready  = !out_valid_r || out_tready;
  assign fire       = pix_valid && pix_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = in_canvas_r;
  assign out_tlast  = last_r;

  // clip against the square canvas and form y*side+x
  always_comb begin
    in_canvas = !pix.x[COORD_W-1] && (pix.x[COORD_W-2:0] < (COORD_W-1)'(CANVAS_SIDE)) &&
                !pix.y[COORD_W-1] && (pix.y[COORD_W-2:0] < (COORD_W-1)'(CANVAS_SIDE));
    addr_full = FULL_W'(pix.y[IDX_W-1:0]) * FULL_W'(CANVAS_SIDE) +
                FULL_W'(pix.x[IDX_W-1:0]);
    addr = in_canvas ? addr_full[ADDR_W-1:0] : '0;
  end

  always_comb begin
    out_valid_nxt = fire ? 1'b1 : (out_valid_r && !out_tready);
    data_nxt      = fire ? {1'b0, pix.color, addr, pix.y, pix.x} : data_r;
    in_canvas_nxt = fire ? in_canvas : in_canvas_r;
    last_nxt      = fire ? pix.last : last_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    data_r      <= data_nxt;
    in_canvas_r <= in_canvas_nxt;
    last_r      <= last_nxt;
  end

endmodule

`default_nettype wire

### rtl/bresenham_line_pixel_stepper_top.sv
// top level of the line pixel stepper: input register, stepper, clip and address stage
`default_nettype none

// Line rasterizer. A load transaction (tuser = 0) brings start and end points
// and a color and gives no output; each step transaction (tuser = 1) then
// gives one pixel, start point first, with tlast on the end point. A step with
// no line loaded gives nothing, and a load replaces any line under way. One
// transaction is taken every clock while the output is not stalled; a pixel
// leaves through the input register, stepper register and address register.
// The stepper register holds the line state, so each step's error update and
// unit move are done together by its next-state logic. Pixels outside the
// CANVAS_SIDE square carry tuser = 0 and address 0.

module bresenham_line_pixel_stepper_top
  import blps_pkg::*;
#(
  parameter int CANVAS_SIDE = 2560
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // pixel_x, pixel_y, pixel_address, pixel_color, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // inside_res
  output logic                       out_tuser,
  output logic                       out_tlast
);

  logic       in_valid_r, in_valid_nxt;
  line_item_t item_r, item_nxt;
  logic       step_ready;
  logic       pix_valid;
  pixel_t     pix;
  logic       pix_ready;

  assign in_tready = !in_valid_r || step_ready;

  // input register
  always_comb begin
    in_valid_nxt = in_tready ? in_tvalid : in_valid_r;
    item_nxt     = item_r;
    if (in_tvalid && in_tready) begin
      item_nxt.op         = op_t'(in_tuser);
      item_nxt.start_x    = in_tdata[15:0];
      item_nxt.start_y    = in_tdata[31:16];
      item_nxt.end_x      = in_tdata[47:32];
      item_nxt.end_y      = in_tdata[63:48];
      item_nxt.line_color = in_tdata[95:64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    item_r <= item_nxt;
  end

  blps_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (item_r),
    .item_ready (step_ready),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .pix_ready  (pix_ready)
  );

  blps_addr #(
    .CANVAS_SIDE (CANVAS_SIDE)
  ) u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .pix_ready  (pix_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### sim/tb_bresenham_line_pixel_stepper_top.sv
// self-checking testbench of the line pixel stepper: predicts every pixel and compares
`timescale 1ns / 1ps

import blps_pkg::*;

// one pixel as it should leave the block
typedef struct {
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic                      in_canvas;
  logic [ADDR_W-1:0]         addr;
  logic [COLOR_W-1:0]        color;
  logic                      last;
} canvas_pixel_t;

// line walker that tracks the block and holds the pixels still owed
class pixel_checker;
  int canvas_side;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic [LEN_W-1:0] major_len, minor_len, steps_left;
  logic [ERR_W-1:0] error_acc;
  logic x_neg, y_neg, x_major, tracing, first_due;
  logic [COLOR_W-1:0] color;
  canvas_pixel_t pending_pixels[$];
  int mismatches;

  function new(int side);
    canvas_side = side;
    cur_x = '0;
    cur_y = '0;
    major_len = '0;
    minor_len = '0;
    steps_left = '0;
    error_acc = '0;
    x_neg = 1'b0;
    y_neg = 1'b0;
    x_major = 1'b0;
    tracing = 1'b0;
    first_due = 1'b0;
    color = '0;
    mismatches = 0;
  endfunction

  // apply one accepted transaction, return 1 when it does any work
  function bit note_input(line_item_t item);
    int dx, dy, ax, ay;
    bit minor_step;
    canvas_pixel_t px;
    if (item.op == OP_LOAD) begin
      dx = int'(item.end_x) - int'(item.start_x);
      dy = int'(item.end_y) - int'(item.start_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      cur_x = item.start_x;
      cur_y = item.start_y;
      // a zero delta counts as negative, the axis never moves anyway
      x_neg = !(dx > 0);
      y_neg = !(dy > 0);
      x_major = ax > ay;
      major_len = x_major ? LEN_W'(ax) : LEN_W'(ay);
      minor_len = x_major ? LEN_W'(ay) : LEN_W'(ax);
      error_acc = ERR_W'(major_len >> 1);
      steps_left = major_len;
      color = item.line_color;
      tracing = 1'b1;
      first_due = 1'b1;
      return 1'b1;
    end
    if (!tracing) return 1'b0;
    // the start point goes out unmoved
    if (first_due) begin
      first_due = 1'b0;
    end else begin
      error_acc = error_acc + minor_len;
      minor_step = error_acc >= major_len;
      if (minor_step) error_acc = error_acc - major_len;
      if (x_major) begin
        cur_x += x_neg ? -16'sd1 : 16'sd1;
        if (minor_step) cur_y += y_neg ? -16'sd1 : 16'sd1;
      end else begin
        cur_y += y_neg ? -16'sd1 : 16'sd1;
        if (minor_step) cur_x += x_neg ? -16'sd1 : 16'sd1;
      end
      if (steps_left > 0) steps_left = steps_left - 1'b1;
    end
    // clip against the square canvas
    px.x = cur_x;
    px.y = cur_y;
    px.in_canvas = (cur_x >= 0) && (cur_x < canvas_side) &&
                   (cur_y >= 0) && (cur_y < canvas_side);
    px.addr = px.in_canvas ? ADDR_W'(int'(cur_y) * canvas_side + int'(cur_x)) : '0;
    px.color = color;
    px.last = (steps_left == 0);
    if (px.last) tracing = 1'b0;
    pending_pixels.push_back(px);
    return 1'b1;
  endfunction

  task report(string line);
    if (mismatches < 100) $display("pixel mismatch: %s", line);
    mismatches++;
  endtask

  // compare one accepted output transaction with the oldest owed pixel
  task check_result(logic [OUT_DATA_W-1:0] data, logic in_canvas, logic last);
    canvas_pixel_t want;
    if (pending_pixels.size() == 0) begin
      report($sformatf("unexpected pixel x %0d y %0d", $signed(data[15:0]),
                       $signed(data[31:16])));
      return;
    end
    want = pending_pixels.pop_front();
    if (data[15:0] !== want.x)
      report($sformatf("x got %0d expected %0d", $signed(data[15:0]), want.x));
    if (data[31:16] !== want.y)
      report($sformatf("y got %0d expected %0d", $signed(data[31:16]), want.y));
    if (in_canvas !== want.in_canvas)
      report($sformatf("in canvas got %0b expected %0b at (%0d,%0d)", in_canvas,
                       want.in_canvas, want.x, want.y));
    if (data[54:32] !== want.addr)
      report($sformatf("address got %0d expected %0d at (%0d,%0d)", data[54:32],
                       want.addr, want.x, want.y));
    if (data[86:55] !== want.color)
      report($sformatf("color got %0h expected %0h", data[86:55], want.color));
    if (last !== want.last)
      report($sformatf("last got %0b expected %0b at (%0d,%0d)", last, want.last,
                       want.x, want.y));
  endtask
endclass

module tb_bresenham_line_pixel_stepper_top;

  localparam int CANVAS_SIDE = 2560;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  logic rx_hold = 1'b0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int work_items = 0;
  pixel_checker sb = new(CANVAS_SIDE);

  bresenham_line_pixel_stepper_top #(
    .CANVAS_SIDE(CANVAS_SIDE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  // receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // offer one transaction, with random gaps ahead of it, and wait for acceptance
  task automatic send_item(input op_t op, input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                           input logic [COLOR_W-1:0] color);
    line_item_t item;
    item.op = op;
    item.start_x = sx;
    item.start_y = sy;
    item.end_x = ex;
    item.end_y = ey;
    item.line_color = color;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {color, ey, ex, sy, sx};
    do @(posedge clk); while (!in_tready);
    if (sb.note_input(item)) work_items++;
  endtask

  // step with junk in the unused data fields
  task automatic step_pixel();
    send_item(OP_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), $urandom);
  endtask

  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // coordinate mostly on or around the canvas
  function automatic logic signed [COORD_W-1:0] near_canvas();
    case ($urandom_range(0, 9))
      0, 1: return COORD_W'(int'($urandom_range(0, 16)) - 8);
      2, 3: return COORD_W'(CANVAS_SIDE - 8 + int'($urandom_range(0, 16)));
      4: return COORD_W'($urandom);
      default: return COORD_W'($urandom_range(0, CANVAS_SIDE - 1));
    endcase
  endfunction

  task automatic directed_cases();
    // step with no line loaded
    step_pixel();
    // zero-length line, then a step after its only pixel
    send_item(OP_LOAD, 5, 5, 5, 5, 32'hffff_ffff);
    step_pixel();
    step_pixel();
    // steep line leaving the canvas at the far corner
    send_item(OP_LOAD, 2557, 2557, 2560, 2561, 32'h0000_0000);
    repeat (5) step_pixel();
    // full-range diagonal, cut short by the next load
    send_item(OP_LOAD, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 32'ha5a5_5a5a);
    step_pixel();
    step_pixel();
    // horizontal line across the left edge
    send_item(OP_LOAD, -2, 3, 3, 3, 32'h1234_5678);
    repeat (6) step_pixel();
    // vertical line above the canvas
    send_item(OP_LOAD, 10, -3, 10, -1, 32'h8000_0001);
    repeat (3) step_pixel();
    // equal deltas at the bottom-left corner
    send_item(OP_LOAD, 0, 2559, -1, 2560, 32'h5a5a_a5a5);
    repeat (2) step_pixel();
    // line at the top of the coordinate range
    send_item(OP_LOAD, 16'sh7fff, 0, 32760, 16'sh8000, 32'h0f0f_f0f0);
    step_pixel();
  endtask

  // mostly whole lines with random content, some cut short, some noise
  task automatic random_traffic(input int target);
    int first_count, kind, span, off_x, off_y;
    logic signed [COORD_W-1:0] sx, sy;
    first_count = work_items;
    while (work_items - first_count < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        sx = near_canvas();
        sy = near_canvas();
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
        off_x = int'($urandom_range(0, 2 * span)) - span;
        off_y = int'($urandom_range(0, 2 * span)) - span;
        send_item(OP_LOAD, sx, sy, COORD_W'(int'(sx) + off_x), COORD_W'(int'(sy) + off_y),
                  $urandom);
        while (sb.tracing) begin
          if ($urandom_range(0, 39) == 0) break;
          step_pixel();
        end
      end else if (kind < 18) begin
        send_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), $urandom);
        repeat ($urandom_range(1, 6)) step_pixel();
      end else begin
        repeat ($urandom_range(1, 3)) step_pixel();
      end
    end
  endtask

  // run limit
  initial begin
    #10_000_000;
    $display("bresenham_line_pixel_stepper_top regression: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 27;
    rx_idle_pct = 47;
    directed_cases();
    random_traffic(530);
    tx_idle_pct = 47;
    rx_idle_pct = 27;
    random_traffic(530);
    // no idling, but one long receiver hold-off to back up the block
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      hold_receiver(400);
    join_none
    random_traffic(540);
    in_tvalid <= 1'b0;
    // drain the owed pixels, then let the pipeline settle
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("bresenham_line_pixel_stepper_top regression: pass");
    end else begin
      $display("bresenham_line_pixel_stepper_top regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/blps_pkg.sv
rtl/blps_step.sv
rtl/blps_addr.sv
rtl/bresenham_line_pixel_stepper_top.sv
sim/tb_bresenham_line_pixel_stepper_top.sv
